[rtl/rsv_pkg.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator package
// Shared widths, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package rsv_pkg;

  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 8;
  localparam int DIM_BITS    = 11;
  localparam int INDEX_BITS  = 30;
  localparam int DENS_BITS   = 8;
  localparam int SUM_BITS    = 2 * COORD_BITS;
  localparam int ROOT_BITS   = COORD_BITS + FRAC_BITS;
  localparam int REM_BITS    = 2 * ROOT_BITS + 2;
  localparam int DIV_BITS    = ROOT_BITS + DENS_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CFG_DIM_X = 2'd0;
  localparam logic [1:0] CFG_DIM_Y = 2'd1;
  localparam logic [1:0] CFG_DIM_Z = 2'd2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(64);

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [SUM_BITS-1:0]   sum;
    logic [COORD_BITS-1:0] radius;
    logic                  zero;
    logic                  in_sphere;
  } item_t;

endpackage

[rtl/rsv_front.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator front end
// Holds the extents, forms the address and squared distance and classifies
// each voxel against the sphere radius.
// ----------------------------------------------------------------------------
module rsv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [rsv_pkg::DIM_BITS-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_x,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_y,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_z,
  input  logic                           full,
  output logic                           push,
  output rsv_pkg::item_t                 push_item
);
  import rsv_pkg::*;

  logic [DIM_BITS-1:0]     dim_x, dim_y, dim_z;
  logic [2*DIM_BITS-1:0]   dxdy;
  logic [SUM_BITS-1:0]     rr;
  logic [COORD_BITS-1:0]   radius;
  logic                    adv;
  logic                    v0, v1, v2;
  logic [COORD_BITS-1:0]   x0, y0, z0, x1;
  logic [COORD_BITS-1:0]   dx, dy, dz;
  logic [2*COORD_BITS:0]   ydx1;
  logic [INDEX_BITS-1:0]   zp1;
  logic [31:0]             zprod;
  logic [SUM_BITS-1:0]     sqx1, sqy1, sqz1;
  logic [SUM_BITS+1:0]     sum;
  item_t                   item2;

  function automatic logic [COORD_BITS-1:0] abs_diff(logic [COORD_BITS-1:0] a,
                                                      logic [COORD_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign radius = dim_z[DIM_BITS-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= DIM_RESET;
      dim_y <= DIM_RESET;
      dim_z <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIM_X: dim_x <= cfg_data;
        CFG_DIM_Y: dim_y <= cfg_data;
        CFG_DIM_Z: dim_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dxdy <= {{DIM_BITS{1'b0}}, dim_x} * {{DIM_BITS{1'b0}}, dim_y};
    rr   <= {{COORD_BITS{1'b0}}, radius} * {{COORD_BITS{1'b0}}, radius};
  end

  assign adv       = !v2 || !full;
  assign in_ready  = adv;
  assign push      = v2 && !full;
  assign push_item = item2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  assign dx    = abs_diff(dim_x[DIM_BITS-1:1], x0);
  assign dy    = abs_diff(dim_y[DIM_BITS-1:1], y0);
  assign dz    = abs_diff(radius, z0);
  assign zprod = {{(32-COORD_BITS){1'b0}}, z0} * {{(32-2*DIM_BITS){1'b0}}, dxdy};
  assign sum   = (SUM_BITS+2)'(sqx1) + (SUM_BITS+2)'(sqy1) + (SUM_BITS+2)'(sqz1);

  always_ff @(posedge clk) begin
    if (adv) begin
      x0   <= coord_x;
      y0   <= coord_y;
      z0   <= coord_z;
      x1   <= x0;
      ydx1 <= {{(COORD_BITS+1){1'b0}}, y0} * {{COORD_BITS{1'b0}}, dim_x};
      zp1  <= zprod[INDEX_BITS-1:0];
      sqx1 <= {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
      sqy1 <= {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
      sqz1 <= {{COORD_BITS{1'b0}}, dz} * {{COORD_BITS{1'b0}}, dz};
      item2.index     <= INDEX_BITS'(x1) + INDEX_BITS'(ydx1) + zp1;
      item2.sum       <= sum[SUM_BITS-1:0];
      item2.radius    <= radius;
      item2.zero      <= (radius == '0);
      item2.in_sphere <= (sum < {2'b0, rr});
    end
  end

endmodule

[rtl/rsv_queue.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rsv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsv_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rsv_pkg::item_t pop_item
);
  import rsv_pkg::*;

  item_t                mem [0:QUEUE_DEPTH-1];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;

  assign full     = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/rsv_back.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator back end
// Pipelined square root of the squared distance, one root bit per stage,
// then a pipelined divide that scales the distance into a density.
// ----------------------------------------------------------------------------
module rsv_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  rsv_pkg::item_t                 pop_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsv_pkg::INDEX_BITS-1:0] voxel_index,
  output logic [rsv_pkg::DENS_BITS-1:0]  density,
  output logic                           zero_radius
);
  import rsv_pkg::*;

  logic                  adv;
  logic [ROOT_BITS:0]    svalid;
  logic [REM_BITS-1:0]   srem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]  sroot [0:ROOT_BITS];
  item_t                 smeta [0:ROOT_BITS];
  logic [DENS_BITS:0]    dvalid;
  logic [DIV_BITS-1:0]   drem  [0:DENS_BITS];
  logic [ROOT_BITS-1:0]  dr    [0:DENS_BITS];
  logic [DENS_BITS-1:0]  dq    [0:DENS_BITS];
  item_t                 dmeta [0:DENS_BITS];
  logic [ROOT_BITS-1:0]  rfix, num;

  assign adv = !dvalid[DENS_BITS] || out_ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= '0;
      dvalid <= '0;
    end else if (adv) begin
      svalid <= {svalid[ROOT_BITS-1:0], !empty};
      dvalid <= {dvalid[DENS_BITS-1:0], svalid[ROOT_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem[0]  <= {2'b0, (pop_item.in_sphere ? pop_item.sum : {SUM_BITS{1'b0}}),
                   {(2*FRAC_BITS){1'b0}}};
      sroot[0] <= '0;
      smeta[0] <= pop_item;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int B = ROOT_BITS - 1 - k;
    logic [REM_BITS-1:0] trial;
    assign trial = ({{(REM_BITS-ROOT_BITS){1'b0}}, sroot[k]} << (B + 1))
                 + ({{(REM_BITS-1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        smeta[k+1] <= smeta[k];
        if (srem[k] >= trial) begin
          srem[k+1]  <= srem[k] - trial;
          sroot[k+1] <= sroot[k] | ({{(ROOT_BITS-1){1'b0}}, 1'b1} << B);
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k];
        end
      end
    end
  end

  assign rfix = {smeta[ROOT_BITS].radius, {FRAC_BITS{1'b0}}};
  assign num  = rfix - sroot[ROOT_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      drem[0]  <= {num, {DENS_BITS{1'b0}}} - {{DENS_BITS{1'b0}}, num};
      dr[0]    <= rfix;
      dq[0]    <= '0;
      dmeta[0] <= smeta[ROOT_BITS];
    end
  end

  for (genvar j = 0; j < DENS_BITS; j++) begin : g_div
    localparam int B = DENS_BITS - 1 - j;
    logic [DIV_BITS-1:0] cmp;
    assign cmp = {{DENS_BITS{1'b0}}, dr[j]} << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        dmeta[j+1] <= dmeta[j];
        dr[j+1]    <= dr[j];
        if (drem[j] >= cmp) begin
          drem[j+1] <= drem[j] - cmp;
          dq[j+1]   <= dq[j] | ({{(DENS_BITS-1){1'b0}}, 1'b1} << B);
        end else begin
          drem[j+1] <= drem[j];
          dq[j+1]   <= dq[j];
        end
      end
    end
  end

  assign out_valid   = dvalid[DENS_BITS];
  assign voxel_index = dmeta[DENS_BITS].index;
  assign zero_radius = dmeta[DENS_BITS].zero;
  assign density     = (dmeta[DENS_BITS].in_sphere && !dmeta[DENS_BITS].zero)
                     ? dq[DENS_BITS] : '0;

endmodule

[rtl/radial_sphere_voxel_generator_unit.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator
// Gives the linear address and a radial density for each voxel coordinate.
// ----------------------------------------------------------------------------
// The input channel takes one coordinate request (coord_x, coord_y, coord_z)
// per cycle when nothing stalls, on in_valid/in_ready. The output channel
// returns one result per request, in order, on out_valid/out_ready:
// voxel_index, density and zero_radius.
// The extents dim_x, dim_y and dim_z are written through cfg_write, cfg_index
// and cfg_data; the user must write them only while no request is in flight,
// as the block does not enforce it. Throughput is one request per cycle when
// nothing stalls. The accepting edge loads the first of three front-end
// stages; the request then passes the queue, a load stage and one stage per
// root bit of the square root, and a load stage and one stage per density
// bit of the divide before its result is valid.
// Reset loads all three extents with 64 and empties every stage and the queue.
// When the receiver stalls, the back-end pipeline holds, the queue fills and
// then in_ready drops; no request is lost.
// ----------------------------------------------------------------------------
module radial_sphere_voxel_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [rsv_pkg::DIM_BITS-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_x,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_y,
  input  logic [rsv_pkg::COORD_BITS-1:0] coord_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsv_pkg::INDEX_BITS-1:0] voxel_index,
  output logic [rsv_pkg::DENS_BITS-1:0]  density,
  output logic                           zero_radius
);
  import rsv_pkg::*;

  logic  push, pop, full, empty;
  item_t push_item, pop_item;

  rsv_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .coord_x, .coord_y, .coord_z,
    .full, .push, .push_item
  );

  rsv_queue u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .empty, .pop_item
  );

  rsv_back u_back (
    .clk, .rst, .empty, .pop_item, .pop,
    .out_valid, .out_ready, .voxel_index, .density, .zero_radius
  );

endmodule

[rtl/rsv_checker.sv]
// ----------------------------------------------------------------------------
// Radial sphere voxel generator checker
// Port-level checks on reset behavior, stalls and the result fields.
// ----------------------------------------------------------------------------
module rsv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rsv_pkg::INDEX_BITS-1:0] voxel_index,
  input logic [rsv_pkg::DENS_BITS-1:0]  density,
  input logic                           zero_radius
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(voxel_index)
      && $stable(density) && $stable(zero_radius))
    else $error("stalled result changed");

  a_zero_density: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_radius |-> density == '0)
    else $error("nonzero density with zero radius");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind radial_sphere_voxel_generator_unit rsv_checker u_rsv_checker (.*);

[tb/tb_radial_sphere_voxel_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial sphere voxel generator testbench
// Sends coordinate requests under several volume extents and checks each
// result against a predictor of the address and the radial density.
// ----------------------------------------------------------------------------
module tb_radial_sphere_voxel_generator_unit;
  import rsv_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [INDEX_BITS-1:0] index;
    logic [DENS_BITS-1:0]  dens;
    logic                  zero;
  } voxel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_DIM_X;
  logic [DIM_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_BITS-1:0] voxel_index;
  logic [DENS_BITS-1:0] density;
  logic zero_radius;

  logic [DIM_BITS-1:0] ext_x = 64, ext_y = 64, ext_z = 64;
  voxel_t pending_voxels[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  bit long_gaps = 1'b1;

  radial_sphere_voxel_generator_unit dut (.*);

  always #1 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_dist(longint unsigned c, longint unsigned p);
    longint unsigned d;
    d = (c >= p) ? c - p : p - c;
    return d * d;
  endfunction

  function automatic voxel_t predict_voxel(logic [COORD_BITS-1:0] x, y, z);
    voxel_t v;
    longint unsigned r, s, dfix, rfix, idx;
    r = ext_z >> 1;
    idx = x + y * ext_x + z * ext_x * ext_y;
    v.index = idx[INDEX_BITS-1:0];
    v.dens = '0;
    v.zero = (r == 0);
    s = sq_dist(ext_x >> 1, x) + sq_dist(ext_y >> 1, y) + sq_dist(r, z);
    if (r != 0 && s < r * r) begin
      dfix = int_sqrt(s << (2 * FRAC_BITS));
      rfix = r << FRAC_BITS;
      if (dfix < rfix) v.dens = DENS_BITS'((255 * (rfix - dfix)) / rfix);
    end
    return v;
  endfunction

  task automatic send_voxel(logic [COORD_BITS-1:0] x, y, z);
    int gap;
    gap = ($urandom_range(0, 9) == 0 && long_gaps) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 1);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    pending_voxels.push_back(predict_voxel(x, y, z));
    requests_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_voxels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_extent(logic [1:0] idx, logic [DIM_BITS-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DIM_X: ext_x = val;
      CFG_DIM_Y: ext_y = val;
      CFG_DIM_Z: ext_z = val;
      default: ;
    endcase
  endtask

  task automatic set_extents(logic [DIM_BITS-1:0] x, y, z);
    write_extent(CFG_DIM_X, x);
    write_extent(CFG_DIM_Y, y);
    write_extent(CFG_DIM_Z, z);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(logic [DIM_BITS-1:0] ext);
    if (ext == 0 || $urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, (ext > 1024) ? 1023 : ext - 1);
  endfunction

  task automatic send_random(int n);
    repeat (n) send_voxel(pick_coord(ext_x), pick_coord(ext_y), pick_coord(ext_z));
  endtask

  task automatic test_directed();
    send_voxel(32, 32, 32);
    send_voxel(0, 0, 0);
    send_voxel(63, 63, 63);
    send_voxel(32, 32, 0);
    send_voxel(32, 32, 1);
    send_voxel(1023, 1023, 1023);
    send_voxel(10'h2AA, 10'h155, 10'h2AA);
    send_voxel(10'h155, 10'h2AA, 10'h155);
    set_extents(1024, 1024, 1024);
    send_voxel(512, 512, 512);
    send_voxel(1023, 1023, 1023);
    send_voxel(0, 512, 1023);
    write_extent(CFG_DIM_Z, 1);
    send_voxel(0, 0, 0);
    send_voxel(512, 512, 0);
    write_extent(CFG_DIM_Z, 0);
    send_voxel(5, 6, 7);
    set_extents(2047, 2047, 2047);
    send_voxel(1023, 1023, 1023);
    send_voxel(0, 0, 0);
    set_extents(0, 0, 2);
    send_voxel(0, 0, 1);
    send_voxel(1, 1, 1);
    write_extent(CFG_UNUSED, 7);
    send_voxel(0, 0, 0);
  endtask

  task automatic test_random_extents();
    logic [DIM_BITS-1:0] sizes[6] = '{1, 2, 3, 64, 1024, 2047};
    repeat (12) begin
      if ($urandom_range(0, 1) == 0)
        set_extents(sizes[$urandom_range(0, 5)], sizes[$urandom_range(0, 5)],
                    sizes[$urandom_range(0, 5)]);
      else
        set_extents($urandom_range(1, 1024), $urandom_range(1, 1024),
                    $urandom_range(1, 1024));
      send_random(108);
    end
  endtask

  task automatic test_backpressure();
    set_extents(40, 40, 40);
    hold_receiver = 1'b1;
    long_gaps = 1'b0;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_receiver = 1'b0;
      end
      send_random(80);
    join
    long_gaps = 1'b1;
    drain();
    send_random(50);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_receiver) begin
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: out_ready <= 1'b0;
        1, 2, 3: out_ready <= $urandom_range(0, 1);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    voxel_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_voxels.size() == 0) begin
        $error("unexpected result index=%0d", voxel_index);
        errors++;
      end else begin
        e = pending_voxels.pop_front();
        if (voxel_index !== e.index) begin
          $error("voxel_index expected %0d actual %0d", e.index, voxel_index);
          errors++;
        end
        if (density !== e.dens) begin
          $error("density expected %0d actual %0d", e.dens, density);
          errors++;
        end
        if (zero_radius !== e.zero) begin
          $error("zero_radius expected %0d actual %0d", e.zero, zero_radius);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_extents();
    drain();
    if (pending_voxels.size() != 0) begin
      $error("%0d results never arrived", pending_voxels.size());
      errors++;
    end
    $display("Sent %0d requests across fixed and random extents, checked %0d results.",
             requests_sent, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
